@@ rtl/sem_pkg.sv @@
`timescale 1ns / 1ps

package sem_pkg;

    // channel sum of one pixel, 0..765
    typedef logic [9:0] sum_t;

    // absolute gradient, 0..3060
    typedef logic [11:0] grad_t;

    // gx*gx + gy*gy
    typedef logic [24:0] sq_t;

    localparam int DEFAULT_MAX_WIDTH = 2048;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 13;

    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    localparam int WIDTH_RESET  = 640;
    localparam int HEIGHT_RESET = 480;
    localparam int HEIGHT_LIMIT = 4096;

endpackage

@@ rtl/sem_pixel_if.sv @@
`timescale 1ns / 1ps

interface sem_pixel_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

@@ rtl/sem_result_if.sv @@
`timescale 1ns / 1ps

interface sem_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] magnitude;
    logic       frame_done;

    modport source (output valid, output magnitude, output frame_done, input ready);
    modport sink   (input valid, input magnitude, input frame_done, output ready);
endinterface

@@ rtl/sem_line_store.sv @@
`timescale 1ns / 1ps

// Both line stores share one array: upper sum in the high half, middle in the low.
module sem_line_store import sem_pkg::*;
#(
    parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
)
(
    input  logic                         clk,
    input  logic                         rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
    output sum_t                         rd_upper,
    output sum_t                         rd_middle,
    input  logic                         wr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
    input  sum_t                         wr_upper,
    input  sum_t                         wr_middle
);

    localparam int DW = 2 * $bits(sum_t);

    logic [DW-1:0] mem [MAX_WIDTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_upper, wr_middle};
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_upper  = rd_data_reg[DW-1:$bits(sum_t)];
    assign rd_middle = rd_data_reg[$bits(sum_t)-1:0];

endmodule

@@ rtl/sem_sqrt.sv @@
`timescale 1ns / 1ps

// Bit-serial integer square root, one result bit per cycle, saturating at 255.
module sem_sqrt import sem_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  sq_t        operand,
    output logic       busy,
    output logic       done,
    output logic [7:0] root
);

    logic        busy_reg;
    logic        done_reg;
    logic        sat_reg;
    logic [15:0] s_reg;
    logic [7:0]  root_reg;
    logic [7:0]  bit_reg;
    logic [7:0]  trial;
    logic [15:0] trial_sq;

    assign trial    = root_reg | bit_reg;
    assign trial_sq = 16'(trial) * 16'(trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && (sat_reg || bit_reg[0]))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            s_reg    <= operand[15:0];
            sat_reg  <= |operand[24:16];
            root_reg <= 8'd0;
            bit_reg  <= 8'h80;
        end
        else if (busy_reg)
        begin
            if (sat_reg)
            begin
                root_reg <= 8'hFF;
            end
            else
            begin
                if (trial_sq <= s_reg)
                begin
                    root_reg <= trial;
                end
                bit_reg <= bit_reg >> 1;
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign root = root_reg;

endmodule

@@ rtl/sobel_edge_magnitude_core.sv @@
`timescale 1ns / 1ps

// Sobel 3x3 edge magnitude on a raster RGB stream. Each pixel word is reduced
// to r+g+b; one on-chip array holds the sums of the two previous lines, and a
// six-cell window holds the two previous columns. For every interior pixel one
// result word carries floor(sqrt(gx^2+gy^2)) saturated at 255, with frame_done
// set on the last one of the frame; border pixels and frames narrower or
// shorter than 3 give no result. Pixels are handled one at a time: a border
// pixel is accepted and its line-store entry written back; an interior pixel
// then goes through squaring and the square-root unit, which resolves one
// result bit per cycle and stops early on a sum of squares of 65536 or
// more. A finished result waits in the output register while the
// next pixel is already being worked on. Writing frame_width or frame_height
// restarts the frame (counters and window cleared, line stores kept); width
// is clamped to 1..MAX_WIDTH and height to 1..4096. The line stores have no
// reset and need no clearing pass: within a frame every entry is written
// before it reaches a result.
module sobel_edge_magnitude_core import sem_pkg::*;
#(
    parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    sem_pixel_if.sink              pixel,
    sem_result_if.source           result
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = ($clog2(MAX_WIDTH + 1) > 12) ? $clog2(MAX_WIDTH + 1) : 12;
    localparam int RW = 12;
    localparam int HW = 13;
    localparam int RESET_W = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_READ   = 3'd1;
    localparam logic [2:0] ST_SQUARE = 3'd2;
    localparam logic [2:0] ST_ROOT   = 3'd3;
    localparam logic [2:0] ST_OUT    = 3'd4;

    logic [2:0]    state_reg;
    logic [2:0]    state_next;
    logic [WW-1:0] eff_width_reg;
    logic [HW-1:0] eff_height_reg;
    logic [CW-1:0] col_reg;
    logic [CW-1:0] col_next;
    logic [RW-1:0] row_reg;
    logic [RW-1:0] row_next;
    sum_t          win_reg [6];
    sum_t          bot_reg;
    grad_t         ax_reg;
    grad_t         ay_reg;
    logic          last_reg;
    logic          out_valid_reg;
    logic [7:0]    mag_reg;
    logic          fd_reg;

    logic          accept;
    logic          out_load;
    sum_t          top;
    sum_t          mid;
    logic          interior;
    logic          last_pix;
    logic          col_wrap;
    logic [11:0]   gx_pos;
    logic [11:0]   gx_neg;
    logic [11:0]   gy_pos;
    logic [11:0]   gy_neg;
    grad_t         ax;
    grad_t         ay;
    sq_t           sq_sum;
    logic          sqrt_busy;
    logic          sqrt_done;
    logic [7:0]    sqrt_root;
    logic [WW-1:0] width_in;
    logic [WW-1:0] width_eff;
    logic [HW-1:0] height_eff;

    assign accept   = pixel.valid && pixel.ready;
    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || result.ready);

    // line stores: read at accept, written back in the following cycle
    sem_line_store #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_store (
        .clk       (clk),
        .rd_en     (accept),
        .rd_addr   (col_reg),
        .rd_upper  (top),
        .rd_middle (mid),
        .wr_en     (state_reg == ST_READ),
        .wr_addr   (col_reg),
        .wr_upper  (mid),
        .wr_middle (bot_reg)
    );

    assign sq_sum = sq_t'(ax_reg) * sq_t'(ax_reg) + sq_t'(ay_reg) * sq_t'(ay_reg);

    sem_sqrt u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (state_reg == ST_SQUARE),
        .operand (sq_sum),
        .busy    (sqrt_busy),
        .done    (sqrt_done),
        .root    (sqrt_root)
    );

    // clamp of register writes
    always_comb
    begin
        width_in = WW'(cfg_data[11:0]);
        if (width_in == '0)
            width_eff = WW'(1);
        else if (width_in > WW'(MAX_WIDTH))
            width_eff = WW'(MAX_WIDTH);
        else
            width_eff = width_in;

        if (cfg_data == '0)
            height_eff = HW'(1);
        else if (cfg_data > HW'(HEIGHT_LIMIT))
            height_eff = HW'(HEIGHT_LIMIT);
        else
            height_eff = cfg_data;
    end

    // window: w0/w1/w2 = column c-2 (top/mid/bot), w3/w4/w5 = column c-1
    always_comb
    begin
        gx_pos = 12'(win_reg[2]) + {1'b0, win_reg[5], 1'b0} + 12'(bot_reg);
        gx_neg = 12'(win_reg[0]) + {1'b0, win_reg[3], 1'b0} + 12'(top);
        gy_pos = 12'(top) + {1'b0, mid, 1'b0} + 12'(bot_reg);
        gy_neg = 12'(win_reg[0]) + {1'b0, win_reg[1], 1'b0} + 12'(win_reg[2]);
        ax     = (gx_pos >= gx_neg) ? gx_pos - gx_neg : gx_neg - gx_pos;
        ay     = (gy_pos >= gy_neg) ? gy_pos - gy_neg : gy_neg - gy_pos;
    end

    always_comb
    begin
        interior = (row_reg >= RW'(2)) && (col_reg >= CW'(2));
        col_wrap = (WW'(col_reg) + WW'(1)) >= eff_width_reg;
        last_pix = ((HW'(row_reg) + HW'(1)) >= eff_height_reg) && col_wrap;
        col_next = col_reg + CW'(1);
        row_next = row_reg;
        if (col_wrap)
        begin
            col_next = '0;
            row_next = ((HW'(row_reg) + HW'(1)) >= eff_height_reg) ? '0 : row_reg + RW'(1);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_READ;
            end
            ST_READ:
            begin
                state_next = interior ? ST_SQUARE : ST_IDLE;
            end
            ST_SQUARE:
            begin
                state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                if (sqrt_done)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            eff_width_reg  <= WW'(RESET_W);
            eff_height_reg <= HW'(HEIGHT_RESET);
            col_reg        <= '0;
            row_reg        <= '0;
            for (int i = 0; i < 6; i++)
                win_reg[i] <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_write)
            begin
                if (cfg_index == CFG_FRAME_WIDTH)
                    eff_width_reg <= width_eff;
                if (cfg_index == CFG_FRAME_HEIGHT)
                    eff_height_reg <= height_eff;
                col_reg <= '0;
                row_reg <= '0;
                for (int i = 0; i < 6; i++)
                    win_reg[i] <= '0;
            end
            else if (state_reg == ST_READ)
            begin
                col_reg    <= col_next;
                row_reg    <= row_next;
                win_reg[0] <= win_reg[3];
                win_reg[1] <= win_reg[4];
                win_reg[2] <= win_reg[5];
                win_reg[3] <= top;
                win_reg[4] <= mid;
                win_reg[5] <= bot_reg;
            end

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
            bot_reg <= sum_t'(pixel.red) + sum_t'(pixel.green) + sum_t'(pixel.blue);
        if (state_reg == ST_READ)
        begin
            ax_reg   <= ax;
            ay_reg   <= ay;
            last_reg <= last_pix;
        end
        if (out_load)
        begin
            mag_reg <= sqrt_root;
            fd_reg  <= last_reg;
        end
    end

    assign pixel.ready       = (state_reg == ST_IDLE);
    assign result.valid      = out_valid_reg;
    assign result.magnitude  = mag_reg;
    assign result.frame_done = fd_reg;

    // ---------------------------------------------------------------- checks

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        WW'(col_reg) < eff_width_reg)
        else $error("column counter beyond frame width");

    a_root_in_time: assert property (@(posedge clk) disable iff (!rst_n)
        sqrt_done |-> (state_reg == ST_ROOT))
        else $error("root result outside its wait state");

    a_root_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SQUARE) |=> sqrt_busy)
        else $error("root unit did not start");

    a_writeback: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> $past(accept))
        else $error("line store write without preceding read");

endmodule

@@ tb/sv/sobel_edge_magnitude_core_tb.sv @@
`timescale 1ns / 1ps

// Testbench for sobel_edge_magnitude_core.
// Pixel words go in through sem_pixel_if, edge words come back through
// sem_result_if. A scoreboard object keeps its own line stores, window and
// counters; every accepted pixel may push one expected edge word, and every
// accepted edge word is checked against the oldest one.
module sobel_edge_magnitude_core_tb;
    import sem_pkg::*;

    localparam int STALL_LIMIT   = 2000;  // cycles with no handshake at all
    localparam int SETTLE_CYCLES = 16;    // longer than an interior pixel takes
    localparam int RANDOM_PIXELS = 1100;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [7:0] magnitude;
        logic       frame_done;
    } edge_word_t;

    typedef enum {MODE_UNIFORM, MODE_SMOOTH, MODE_BINARY} pixel_mode_e;

    // Effective frame dimension: 0 acts as 1, anything above the limit is
    // the limit.
    function automatic int clamp_dim(input int value, input int limit);
        if (value == 0)
            return 1;
        if (value > limit)
            return limit;
        return value;
    endfunction

    class edge_scoreboard;
        logic [11:0] width_reg;
        logic [12:0] height_reg;
        sum_t        upper_sums [DEFAULT_MAX_WIDTH];
        sum_t        middle_sums [DEFAULT_MAX_WIDTH];
        sum_t        window [6];
        int          col;
        int          row;
        edge_word_t  expected_q [$];
        int          errors;

        function new();
            width_reg  = 12'(WIDTH_RESET);
            height_reg = 13'(HEIGHT_RESET);
            foreach (upper_sums[i])
            begin
                upper_sums[i]  = '0;
                middle_sums[i] = '0;
            end
            errors = 0;
            restart_frame();
        endfunction

        function void restart_frame();
            foreach (window[i])
                window[i] = '0;
            col = 0;
            row = 0;
        endfunction

        function void write_reg(input logic [CFG_INDEX_W-1:0] index,
                                input logic [CFG_DATA_W-1:0] data);
            case (index)
                CFG_FRAME_WIDTH:  width_reg  = data[11:0];
                CFG_FRAME_HEIGHT: height_reg = data;
                default: ;
            endcase
            restart_frame();
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function logic [7:0] root_of(input int unsigned s);
            int unsigned r;
            if (s >= 65536)
                return 8'd255;
            r = 0;
            while ((r + 1) * (r + 1) <= s)
                r++;
            return r[7:0];
        endfunction

        function void note_pixel(input pixel_t p);
            int          w;
            int          h;
            int          bot;
            int          top;
            int          mid;
            int          gx;
            int          gy;
            int unsigned ax;
            int unsigned ay;
            edge_word_t  word;
            w   = clamp_dim(int'(width_reg), DEFAULT_MAX_WIDTH);
            h   = clamp_dim(int'(height_reg), HEIGHT_LIMIT);
            bot = int'(p.red) + int'(p.green) + int'(p.blue);
            top = int'(upper_sums[col]);
            mid = int'(middle_sums[col]);
            upper_sums[col]  = mid[9:0];
            middle_sums[col] = bot[9:0];
            if (row >= 2 && col >= 2)
            begin
                // window[0..2]: column c-2 (top, mid, bot); window[3..5]: column c-1
                gx = -int'(window[0]) - 2 * int'(window[3]) - top
                     + int'(window[2]) + 2 * int'(window[5]) + bot;
                gy = -int'(window[0]) - 2 * int'(window[1]) - int'(window[2])
                     + top + 2 * mid + bot;
                ax = (gx < 0) ? -gx : gx;
                ay = (gy < 0) ? -gy : gy;
                word.magnitude  = root_of(ax * ax + ay * ay);
                word.frame_done = (row + 1 >= h) && (col + 1 >= w);
                expected_q.push_back(word);
            end
            window[0] = window[3];
            window[1] = window[4];
            window[2] = window[5];
            window[3] = top[9:0];
            window[4] = mid[9:0];
            window[5] = bot[9:0];
            col++;
            if (col >= w)
            begin
                col = 0;
                row++;
                if (row >= h)
                    row = 0;
            end
        endfunction

        function void check_result(input logic [7:0] magnitude, input logic frame_done);
            edge_word_t want;
            if (expected_q.size() == 0)
            begin
                $error("edge word with nothing expected: magnitude=%0d frame_done=%0d",
                       magnitude, frame_done);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (magnitude !== want.magnitude)
            begin
                $error("magnitude: expected %0d, actual %0d", want.magnitude, magnitude);
                errors++;
            end
            if (frame_done !== want.frame_done)
            begin
                $error("frame_done: expected %0d, actual %0d", want.frame_done, frame_done);
                errors++;
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // steady = 1: neither side inserts idle cycles
    logic                   steady;
    int                     smooth_level;
    int                     quiet_cycles;
    edge_scoreboard         sb;

    sem_pixel_if  pixel_bus ();
    sem_result_if result_bus ();

    sobel_edge_magnitude_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixel     (pixel_bus),
        .result    (result_bus)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side: ready drops about a quarter of the time unless steady.
    always @(negedge clk)
        result_bus.ready <= steady || ($urandom_range(0, 99) >= 25);

    // Everything is sampled at the rising edge. The edge word is checked
    // before the pixel of the same edge is noted, so a stray word can never
    // match an expectation pushed at that very edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_bus.valid && result_bus.ready)
                sb.check_result(result_bus.magnitude, result_bus.frame_done);
            if (pixel_bus.valid && pixel_bus.ready)
                sb.note_pixel('{pixel_bus.red, pixel_bus.green, pixel_bus.blue});
            if (cfg_write)
                sb.write_reg(cfg_index, cfg_data);

            if ((result_bus.valid && result_bus.ready) ||
                (pixel_bus.valid && pixel_bus.ready) || cfg_write)
                quiet_cycles <= 0;
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Pixel content. Smooth mode walks a slowly drifting gray level with a
    // little noise so the magnitude lands below saturation; uniform mode
    // mostly saturates; binary mode gives hard edges and flat areas.
    function automatic pixel_t next_pixel(input pixel_mode_e mode);
        pixel_t p;
        case (mode)
            MODE_UNIFORM:
            begin
                p.red   = $urandom_range(0, 255);
                p.green = $urandom_range(0, 255);
                p.blue  = $urandom_range(0, 255);
            end
            MODE_SMOOTH:
            begin
                smooth_level = smooth_level + int'($urandom_range(0, 4)) - 2;
                if (smooth_level < 8)
                    smooth_level = 8;
                if (smooth_level > 247)
                    smooth_level = 247;
                p.red   = 8'(smooth_level + int'($urandom_range(0, 6)) - 3);
                p.green = 8'(smooth_level + int'($urandom_range(0, 6)) - 3);
                p.blue  = 8'(smooth_level + int'($urandom_range(0, 6)) - 3);
            end
            default:
            begin
                p.red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                p.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                p.blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
        endcase
        return p;
    endfunction

    // Wait for every edge word, then give a pixel that makes no word time to
    // finish inside the core.
    task automatic wait_drained();
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Writes both registers on consecutive cycles; each write restarts the
    // frame. Entered and left at a falling edge with the core idle.
    task automatic configure(input int width_val, input int height_val);
        wait_drained();
        cfg_write <= 1'b1;
        cfg_index <= CFG_FRAME_WIDTH;
        cfg_data  <= CFG_DATA_W'(width_val);
        @(negedge clk);
        cfg_index <= CFG_FRAME_HEIGHT;
        cfg_data  <= CFG_DATA_W'(height_val);
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // One pixel word. Entered at a falling edge; valid stays high into the
    // next call unless that call opens a gap.
    task automatic send_pixel(input pixel_t p);
        if (!steady)
            while ($urandom_range(0, 99) < 25)
            begin
                pixel_bus.valid <= 1'b0;
                @(negedge clk);
            end
        pixel_bus.valid <= 1'b1;
        pixel_bus.red   <= p.red;
        pixel_bus.green <= p.green;
        pixel_bus.blue  <= p.blue;
        do
            @(posedge clk);
        while (!pixel_bus.ready);
        @(negedge clk);
    endtask

    // pause_at >= 0: hold the pixel side at that point until the result side
    // has drained completely.
    task automatic stream(input pixel_mode_e mode, input int count, input int pause_at);
        for (int i = 0; i < count; i++)
        begin
            if (i == pause_at)
            begin
                pixel_bus.valid <= 1'b0;
                @(negedge clk);
                while (sb.pending() != 0)
                    @(negedge clk);
            end
            send_pixel(next_pixel(mode));
        end
        pixel_bus.valid <= 1'b0;
    endtask

    // 5x5 hand-made frame: dark top rows under a white band give saturated
    // words; the bottom row dims by one per column, giving small non-zero
    // magnitudes; the last word carries frame_done.
    function automatic pixel_t directed_pixel(input int r, input int c);
        if (r < 2)
            return '{8'(c), 8'h00, 8'h00};
        if (r < 4)
            return '{8'hFF, 8'hFF, 8'hFF};
        return '{8'hFF, 8'hFF, 8'(255 - c)};
    endfunction

    initial
    begin
        int          sent;
        int          sel;
        int          w;
        int          h;
        int          area;
        int          count;
        bit          first_phase;
        pixel_mode_e mode;

        clk              = 1'b0;
        rst_n            = 1'b0;
        cfg_write        = 1'b0;
        cfg_index        = CFG_FRAME_WIDTH;
        cfg_data         = '0;
        pixel_bus.valid  = 1'b0;
        pixel_bus.red    = '0;
        pixel_bus.green  = '0;
        pixel_bus.blue   = '0;
        result_bus.ready = 1'b0;
        steady           = 1'b0;
        smooth_level     = 128;
        quiet_cycles     = 0;
        sb               = new();

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed frame
        configure(5, 5);
        for (int r = 0; r < 5; r++)
            for (int c = 0; c < 5; c++)
                send_pixel(directed_pixel(r, c));
        pixel_bus.valid <= 1'b0;

        // Small and out-of-range frame sizes: none of these give a word,
        // except the 3x3 frames, which give exactly one each.
        configure(0, 0);
        stream(MODE_UNIFORM, 4, -1);
        configure(1, 1);
        stream(MODE_UNIFORM, 5, -1);
        configure(2, 9);
        stream(MODE_UNIFORM, 20, -1);
        configure(9, 2);
        stream(MODE_UNIFORM, 20, -1);
        configure(3, 3);
        stream(MODE_BINARY, 18, -1);

        // Long stretch across two frame ends with no idle cycles on
        // either side.
        steady = 1'b1;
        configure(16, 6);
        stream(MODE_SMOOTH, 240, -1);
        steady = 1'b0;

        // Width above its limit with height at it, then height above it: clamped to the limit.
        configure(4095, HEIGHT_LIMIT);
        stream(MODE_SMOOTH, 100, -1);
        configure(3, 8191);
        stream(MODE_BINARY, 125, -1);

        // Random frames: mostly small sizes, one to three frames per setting (a part of one for heights
        // above 8) and usually a partial one before the next write restarts the frame.
        sent        = 0;
        first_phase = 1'b1;
        while (sent < RANDOM_PIXELS)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 65)
            begin
                w = $urandom_range(3, 10);
                h = $urandom_range(3, 8);
            end
            else if (sel < 75)
            begin
                w = $urandom_range(0, 2);
                h = $urandom_range(0, 6);
            end
            else if (sel < 85)
            begin
                w = $urandom_range(3, 8);
                h = $urandom_range(0, 2);
            end
            else if (sel < 92)
            begin
                w = $urandom_range(11, 40);
                h = $urandom_range(3, 5);
            end
            else
            begin
                w = $urandom_range(3, 6);
                h = $urandom_range(HEIGHT_LIMIT + 1, 8191);
            end
            area = clamp_dim(w, DEFAULT_MAX_WIDTH) * clamp_dim(h, HEIGHT_LIMIT);
            if (clamp_dim(h, HEIGHT_LIMIT) > 8)
                count = clamp_dim(w, DEFAULT_MAX_WIDTH) * $urandom_range(3, 8)
                        + $urandom_range(0, 5);
            else
                count = area * $urandom_range(1, 3) + $urandom_range(0, area - 1);
            mode   = pixel_mode_e'($urandom_range(0, 2));
            steady = ($urandom_range(0, 9) == 0);
            configure(w, h);
            stream(mode, count, first_phase ? count / 2 : -1);
            first_phase = 1'b0;
            sent += count;
        end
        steady = 1'b0;

        while (sb.pending() != 0)
            @(negedge clk);
        repeat (2 * SETTLE_CYCLES) @(negedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
